// File: rtl/wmsr_pkg.sv
// Shared types and constants of the wavetable morph sample readout.
// Used by the front, the back and the top level; depends on nothing.
package wmsr_pkg;

  // Field widths sized for the largest supported table geometry.
  localparam int ROW_W  = 18;
  localparam int SAMP_W = 12;
  localparam int FRAC_W = 16;
  localparam int VAL_W  = 16;

  // Queue depths between the parts.
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    logic                    render;
    logic                    wr_ok;
    logic [ROW_W-1:0]        row_a;
    logic [ROW_W-1:0]        row_b;
    logic [SAMP_W-1:0]       samp_a;
    logic [SAMP_W-1:0]       samp_b;
    logic [FRAC_W-1:0]       sfrac;
    logic [FRAC_W-1:0]       ffrac;
    logic [VAL_W-1:0]        wvalue;
  } cmd_t;

endpackage

// File: rtl/wmsr_fifo.sv
// Small synchronous queue with registered storage and a count.
// Generic; depends on nothing. DEPTH must be a power of two.
module wmsr_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/wmsr_front.sv
// Front part: clamps the table index, splits morph position and phase into
// indices and fractions, and forms store rows. Depends on wmsr_pkg.
module wmsr_front #(
  parameter int TABLES     = 64,
  parameter int FRAMES     = 16,
  parameter int FRAME_SIZE = 256
) (
  input  logic [6:0]      table_count,
  input  logic            func,
  input  logic [5:0]      table_index,
  input  logic [3:0]      frame_index,
  input  logic [7:0]      sample_index,
  input  logic [15:0]     write_value,
  input  logic [16:0]     position,
  input  logic [31:0]     phase,
  output wmsr_pkg::cmd_t  cmd
);

  localparam int CW = ($clog2(TABLES + 1) > 7) ? $clog2(TABLES + 1) : 7;
  localparam int RW = wmsr_pkg::ROW_W;

  logic [CW-1:0] cnt;
  logic [CW-1:0] idx;
  logic [CW-1:0] tsel;
  logic [RW-1:0] base;
  logic [16:0]   pos_c;
  logic [24:0]   fp;
  logic [8:0]    fa;
  logic [8:0]    fb;
  logic [44:0]   rp;
  logic [12:0]   sa;
  logic [12:0]   sa_inc;
  logic [12:0]   sb;

  always_comb begin
    cnt = CW'(table_count);
    priority if (cnt == '0) begin
      cnt = CW'(1);
    end else if (cnt > CW'(TABLES)) begin
      cnt = CW'(TABLES);
    end
    idx  = CW'(table_index);
    tsel = (idx > cnt - CW'(1)) ? cnt - CW'(1) : idx;
    base = RW'(tsel) * RW'(FRAMES);
  end

  // Morph position picks two neighboring frames; the upper one stops at the
  // last frame.
  always_comb begin
    pos_c = (position > 17'd65536) ? 17'd65536 : position;
    fp    = 25'(pos_c) * 25'(FRAMES - 1);
    fa    = fp[24:16];
    if (fa > 9'(FRAMES - 1)) begin
      fa = 9'(FRAMES - 1);
    end
    fb = fa + 9'd1;
    if (fb > 9'(FRAMES - 1)) begin
      fb = 9'(FRAMES - 1);
    end
  end

  // Phase scaled by the frame size: the integer part is the sample, which
  // wraps to the first sample after the last.
  always_comb begin
    rp     = 45'(phase) * 45'(FRAME_SIZE);
    sa     = rp[44:32];
    sa_inc = sa + 13'd1;
    sb     = (sa_inc >= 13'(FRAME_SIZE)) ? 13'd0 : sa_inc;
  end

  always_comb begin
    cmd.render = func;
    cmd.wr_ok  = (9'(frame_index) < 9'(FRAMES)) && (13'(sample_index) < 13'(FRAME_SIZE));
    cmd.row_a  = func ? base + RW'(fa) : base + RW'(frame_index);
    cmd.row_b  = base + RW'(fb);
    cmd.samp_a = func ? sa[11:0] : 12'(sample_index);
    cmd.samp_b = sb[11:0];
    cmd.sfrac  = rp[31:16];
    cmd.ffrac  = fp[15:0];
    cmd.wvalue = write_value;
  end

endmodule

// File: rtl/wmsr_back.sv
// Back part: owns the sample store, sequences four reads per render on its
// single port, and runs the three interpolations. Depends on wmsr_pkg.
module wmsr_back #(
  parameter int TABLES     = 64,
  parameter int FRAMES     = 16,
  parameter int FRAME_SIZE = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  wmsr_pkg::cmd_t             cmd,
  input  logic                       cmd_valid,
  output logic                       cmd_pop,
  input  logic                       res_taken,
  output logic                       res_push,
  output logic [wmsr_pkg::VAL_W-1:0] res_data
);

  localparam int DEPTH = TABLES * FRAMES * FRAME_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = (TABLES * FRAMES > 1) ? $clog2(TABLES * FRAMES) : 1;
  localparam int SW    = $clog2(FRAME_SIZE);
  localparam int UW    = $clog2(wmsr_pkg::RES_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_A0 = 4'b0001,
    ST_A1 = 4'b0010,
    ST_B0 = 4'b0100,
    ST_B1 = 4'b1000
  } state_t;

  // a + floor((b - a) * f / 65536); the sum never leaves the span of a and b.
  function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] f);
    logic signed [16:0] d;
    logic signed [33:0] p;
    d = $signed({b[15], b}) - $signed({a[15], a});
    p = d * $signed({1'b0, f});
    return a + p[31:16];
  endfunction

  state_t                  state;
  state_t                  state_next;
  logic [15:0]             mem [DEPTH];
  logic [15:0]             rdata;
  logic [AW-1:0]           addr;
  logic [RW-1:0]           row;
  logic [SW-1:0]           samp;
  logic                    mem_we;
  logic                    issue;
  logic [UW-1:0]           used;
  logic                    credit_ok;
  logic                    rd_vld;
  state_t                  rd_step;
  logic [15:0]             rd_sfrac;
  logic [15:0]             rd_ffrac;
  logic [15:0]             first_smp;
  logic [15:0]             va;
  logic [15:0]             vb;
  logic                    fin_vld;
  logic [15:0]             fin_ffrac;

  assign credit_ok = (used < UW'(wmsr_pkg::RES_DEPTH));

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    mem_we     = 1'b0;
    cmd_pop    = 1'b0;
    row        = cmd.row_a[RW-1:0];
    samp       = cmd.samp_a[SW-1:0];
    unique case (state)
      ST_A0: begin
        if (cmd_valid && !cmd.render) begin
          mem_we  = cmd.wr_ok;
          cmd_pop = 1'b1;
        end else if (cmd_valid && credit_ok) begin
          issue      = 1'b1;
          state_next = ST_A1;
        end
      end
      ST_A1: begin
        issue      = 1'b1;
        samp       = cmd.samp_b[SW-1:0];
        state_next = ST_B0;
      end
      ST_B0: begin
        issue      = 1'b1;
        row        = cmd.row_b[RW-1:0];
        state_next = ST_B1;
      end
      ST_B1: begin
        issue      = 1'b1;
        row        = cmd.row_b[RW-1:0];
        samp       = cmd.samp_b[SW-1:0];
        cmd_pop    = 1'b1;
        state_next = ST_A0;
      end
      default: begin
        state_next = ST_A0;
      end
    endcase
    addr = AW'(row) * AW'(FRAME_SIZE) + AW'(samp);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= cmd.wvalue;
    end
    rdata <= mem[addr];
  end

  // A result slot is reserved when a render starts and freed when its word
  // leaves the output queue, so the queue can never overflow.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_A0;
      used    <= '0;
      rd_vld  <= 1'b0;
      rd_step <= ST_A0;
      fin_vld <= 1'b0;
    end else begin
      state   <= state_next;
      rd_vld  <= issue;
      rd_step <= state;
      fin_vld <= rd_vld && (rd_step == ST_B1);
      if ((issue && state == ST_A0) && !res_taken) begin
        used <= used + UW'(1);
      end else if (!(issue && state == ST_A0) && res_taken) begin
        used <= used - UW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_sfrac <= cmd.sfrac;
    rd_ffrac <= cmd.ffrac;
    if (rd_vld) begin
      if (rd_step == ST_A0 || rd_step == ST_B0) begin
        first_smp <= rdata;
      end
      if (rd_step == ST_A1) begin
        va <= lerp(first_smp, rdata, rd_sfrac);
      end
      if (rd_step == ST_B1) begin
        vb        <= lerp(first_smp, rdata, rd_sfrac);
        fin_ffrac <= rd_ffrac;
      end
    end
  end

  assign res_push = fin_vld;
  assign res_data = lerp(va, vb, fin_ffrac);

endmodule

// File: rtl/wavetable_morph_sample_readout.sv
// Top level of the wavetable morph sample readout.
// Depends on wmsr_pkg, wmsr_front, wmsr_fifo and wmsr_back.

// The block holds TABLES wavetables of FRAMES frames of FRAME_SIZE Q1.15
// samples in one single-ported store. A write word (func 0) uses the store
// port once; a render word (func 1) uses it for four reads, one per stored
// sample, and the next word is taken only once all four are issued. Words
// enter a four-deep queue at one per cycle while it is not full, so short
// bursts are absorbed; results wait in a four-deep output queue. The store
// is not cleared at reset: tables must be loaded before they are rendered.
// Write table_count only while idle.
module wavetable_morph_sample_readout #(
  parameter int TABLES     = 64,
  parameter int FRAMES     = 16,
  parameter int FRAME_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [5:0]  table_index,
  input  logic [3:0]  frame_index,
  input  logic [7:0]  sample_index,
  input  logic [15:0] write_value,
  input  logic [16:0] position,
  input  logic [31:0] phase,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] sample
);

  localparam int CMD_W = $bits(wmsr_pkg::cmd_t);

  logic [6:0]                 table_count;
  wmsr_pkg::cmd_t             cmd_in;
  wmsr_pkg::cmd_t             cmd_head;
  logic [CMD_W-1:0]           cmd_head_bits;
  logic                       cmd_empty;
  logic                       cmd_pop;
  logic                       res_push;
  logic [wmsr_pkg::VAL_W-1:0] res_data;
  logic                       res_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= 7'd41;
    end else if (cfg_we) begin
      table_count <= cfg_wdata;
    end
  end

  assign res_taken = pop && !empty;
  assign cmd_head  = cmd_head_bits;

  wmsr_front #(
    .TABLES     (TABLES),
    .FRAMES     (FRAMES),
    .FRAME_SIZE (FRAME_SIZE)
  ) u_front (
    .table_count  (table_count),
    .func         (func),
    .table_index  (table_index),
    .frame_index  (frame_index),
    .sample_index (sample_index),
    .write_value  (write_value),
    .position     (position),
    .phase        (phase),
    .cmd          (cmd_in)
  );

  wmsr_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (wmsr_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_head_bits),
    .full  (full),
    .empty (cmd_empty)
  );

  wmsr_back #(
    .TABLES     (TABLES),
    .FRAMES     (FRAMES),
    .FRAME_SIZE (FRAME_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_valid (!cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_taken (res_taken),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  wmsr_fifo #(
    .WIDTH (wmsr_pkg::VAL_W),
    .DEPTH (wmsr_pkg::RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .pop   (pop),
    .rdata (sample),
    .full  (),
    .empty (empty)
  );

endmodule
